// ===== rtl/lgp_pkg.sv =====
// ----------------------------------------------------------------------------
// lgp_pkg
// Shared constants, codes and types of the light gun and pad port.
// ----------------------------------------------------------------------------
`default_nettype none

package lgp_pkg;

  // screen geometry and sensor window
  localparam int unsigned SCREEN_WIDTH = 256;
  localparam int unsigned SCREEN_LINES = 240;
  localparam int unsigned WIN_HALF     = 8;
  localparam int unsigned BEAM_LAG     = 32;

  // frame store: one brightness flag per pixel, addressed {row, col}
  localparam int unsigned FS_DEPTH = SCREEN_WIDTH * SCREEN_LINES;
  localparam int unsigned FS_AW    = 16;

  // configuration register indexes
  localparam logic CFG_ALLOW_OPP = 1'b0;
  localparam logic CFG_HIT_THR   = 1'b1;

  // command codes
  typedef enum logic [2:0] {
    FUNC_FRAME  = 3'd0,
    FUNC_PIXEL  = 3'd1,
    FUNC_PORT   = 3'd2,
    FUNC_PAD    = 3'd3,
    FUNC_SENSOR = 3'd4
  } func_e;

  // sensor search request
  typedef struct packed {
    logic [7:0] aim_col;
    logic [7:0] aim_row;
    logic [8:0] beam_line;
    logic [8:0] beam_dot;
    logic       rendering;
  } scan_req_t;

  // sensor search status
  typedef struct packed {
    logic busy;
    logic done;
    logic dark;
  } scan_stat_t;

  // bright palette entries seen by the sensor
  function automatic logic is_bright(input logic [5:0] color);
    is_bright = color inside {6'h10, [6'h20:6'h2D], [6'h30:6'h3D]};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/lgp_frame_store.sv =====
// ----------------------------------------------------------------------------
// lgp_frame_store
// Per-pixel brightness memory with one write and one registered read port,
// swept to zero after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module lgp_frame_store (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      we_i,
  input  wire [lgp_pkg::FS_AW-1:0] waddr_i,
  input  wire                      wdata_i,
  input  wire [lgp_pkg::FS_AW-1:0] raddr_i,
  output logic                     rdata_o,
  output logic                     clearing_o
);
  import lgp_pkg::*;

  logic             frame_mem [FS_DEPTH];
  logic [FS_AW-1:0] clr_addr_q, clr_addr_d;
  logic             clearing_q, clearing_d;
  logic             mem_we;
  logic [FS_AW-1:0] mem_waddr;
  logic             mem_wdata;
  logic             rdata_q;

  // clearing sweep, one entry per cycle
  always_comb begin
    clr_addr_d = clr_addr_q;
    clearing_d = clearing_q;
    if (clearing_q) begin
      if (clr_addr_q == FS_AW'(FS_DEPTH - 1)) begin
        clearing_d = 1'b0;
      end else begin
        clr_addr_d = clr_addr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      clearing_q <= 1'b1;
    end else begin
      clr_addr_q <= clr_addr_d;
      clearing_q <= clearing_d;
    end
  end

  // write port shared between sweep and pixel writes
  assign mem_we    = clearing_q | we_i;
  assign mem_waddr = clearing_q ? clr_addr_q : waddr_i;
  assign mem_wdata = clearing_q ? 1'b0 : wdata_i;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      frame_mem[mem_waddr] <= mem_wdata;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    rdata_q <= frame_mem[raddr_i];
  end

  assign rdata_o    = rdata_q;
  assign clearing_o = clearing_q;

endmodule

`default_nettype wire

// ===== rtl/lgp_scan.sv =====
// ----------------------------------------------------------------------------
// lgp_scan
// Sensor search sequencer: walks the window around the aim point through
// the frame store, one pixel per cycle, and counts bright pixels.
// ----------------------------------------------------------------------------
`default_nettype none

module lgp_scan (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      go_i,
  input  lgp_pkg::scan_req_t       req_i,
  input  wire [8:0]                hit_thr_i,
  input  wire                      fs_rdata_i,
  output logic [lgp_pkg::FS_AW-1:0] fs_raddr_o,
  output lgp_pkg::scan_stat_t      stat_o
);
  import lgp_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_e;

  state_e     state_q, state_d;
  logic [7:0] r_q, r_d;
  logic [7:0] c_q, c_d;
  logic [7:0] c0_q, c0_d;
  logic [7:0] c1_q, c1_d;
  logic [7:0] re_q, re_d;
  logic [8:0] bl_q, bl_d;
  logic [8:0] bd_q, bd_d;
  logic       off_q, off_d;
  logic       rd_vld_q, rd_vld_d;
  logic [8:0] count_q, count_d;

  logic       off;
  logic [7:0] r0, c0, c1;
  logic [8:0] c1_sum, lag, rs, re_a, re_m, re;
  logic       empty;
  logic       hit_end;

  // window bounds from the request
  always_comb begin
    off    = req_i.aim_row >= 8'(SCREEN_LINES);
    r0     = (req_i.aim_row >= 8'(WIN_HALF)) ? req_i.aim_row - 8'(WIN_HALF) : 8'd0;
    c0     = (req_i.aim_col >= 8'(WIN_HALF)) ? req_i.aim_col - 8'(WIN_HALF) : 8'd0;
    c1_sum = {1'b0, req_i.aim_col} + 9'(WIN_HALF - 1);
    c1     = (c1_sum > 9'(SCREEN_WIDTH - 1)) ? 8'(SCREEN_WIDTH - 1) : c1_sum[7:0];
    lag    = (req_i.beam_line >= 9'(BEAM_LAG)) ? req_i.beam_line - 9'(BEAM_LAG) : 9'd0;
    rs     = ({1'b0, r0} > lag) ? {1'b0, r0} : lag;
    re_a   = {1'b0, req_i.aim_row} + 9'(WIN_HALF - 1);
    re_m   = (re_a < req_i.beam_line) ? re_a : req_i.beam_line;
    re     = (re_m < 9'(SCREEN_LINES - 1)) ? re_m : 9'(SCREEN_LINES - 1);
    empty  = rs > re;
  end

  // on the beam row only pixels left of the beam are drawn
  assign hit_end = ({1'b0, r_q} == bl_q) && ({1'b0, c_q} >= bd_q);

  // next state and counters
  always_comb begin
    state_d  = state_q;
    r_d      = r_q;
    c_d      = c_q;
    c0_d     = c0_q;
    c1_d     = c1_q;
    re_d     = re_q;
    bl_d     = bl_q;
    bd_d     = bd_q;
    off_d    = off_q;
    rd_vld_d = 1'b0;
    count_d  = (rd_vld_q && fs_rdata_i) ? count_q + 1'b1 : count_q;
    case (state_q)
      S_IDLE: begin
        if (go_i) begin
          count_d = '0;
          off_d   = off;
          r_d     = rs[7:0];
          c_d     = c0;
          c0_d    = c0;
          c1_d    = c1;
          re_d    = re[7:0];
          bl_d    = req_i.beam_line;
          bd_d    = req_i.beam_dot;
          if (off || !req_i.rendering || empty) begin
            state_d = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (hit_end) begin
          state_d = S_DRAIN;
        end else begin
          rd_vld_d = 1'b1;
          if (c_q == c1_q) begin
            if (r_q == re_q) begin
              state_d = S_DRAIN;
            end else begin
              r_d = r_q + 1'b1;
              c_d = c0_q;
            end
          end else begin
            c_d = c_q + 1'b1;
          end
        end
      end
      S_DRAIN: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      rd_vld_q <= 1'b0;
      off_q    <= 1'b0;
      count_q  <= '0;
      r_q      <= '0;
      c_q      <= '0;
      c0_q     <= '0;
      c1_q     <= '0;
      re_q     <= '0;
      bl_q     <= '0;
      bd_q     <= '0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_vld_d;
      off_q    <= off_d;
      count_q  <= count_d;
      r_q      <= r_d;
      c_q      <= c_d;
      c0_q     <= c0_d;
      c1_q     <= c1_d;
      re_q     <= re_d;
      bl_q     <= bl_d;
      bd_q     <= bd_d;
    end
  end

  assign fs_raddr_o  = {r_q, c_q};
  assign stat_o.busy = state_q != S_IDLE;
  assign stat_o.done = state_q == S_DONE;
  assign stat_o.dark = off_q | (count_q < hit_thr_i);

endmodule

`default_nettype wire

// ===== rtl/light_gun_and_pad_port_core.sv =====
// Pad read: result strobe in the cycle after the start transaction; one item per cycle
// while busy is low. Sensor read: the sequencer walks up to 256 window pixels, stopping
// at the beam, then drains the last read and reports; off screen, not drawing or an empty
// window reports without a walk. Frame latch, pixel write and port write give no result.
// After reset busy stays high while the frame store is swept to zero.
// Results cannot be stalled: res_valid_o is high for exactly one cycle per result.
// ----------------------------------------------------------------------------
// light_gun_and_pad_port_core
// Game-port device with a serial 8-button pad and a light sensor that
// searches a stored frame for bright pixels around the aim point.
// ----------------------------------------------------------------------------
`default_nettype none

module light_gun_and_pad_port_core (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       start,
  output logic      busy,
  input  wire [2:0] func_i,
  input  wire [7:0] buttons_i,
  input  wire [7:0] aim_x_i,
  input  wire [7:0] aim_y_i,
  input  wire [7:0] pixel_row_i,
  input  wire [7:0] pixel_col_i,
  input  wire [5:0] pixel_color_i,
  input  wire       strobe_bit_i,
  input  wire [8:0] beam_line_i,
  input  wire [8:0] beam_dot_i,
  input  wire       rendering_i,
  input  wire       cfg_we_i,
  input  wire       cfg_idx_i,
  input  wire [8:0] cfg_data_i,
  output logic      res_valid_o,
  output logic [4:0] read_data_o
);
  import lgp_pkg::*;

  logic                 accept;
  func_e                func;
  logic                 allow_opp_q;
  logic [8:0]           hit_thr_q;
  logic [7:0]           shift_q, shift_d;
  logic [3:0]           bit_idx_q, bit_idx_d;
  logic                 strobe_q, strobe_d;
  logic [7:0]           buttons_q, buttons_d;
  logic [7:0]           aim_col_q, aim_col_d;
  logic [7:0]           aim_row_q, aim_row_d;
  logic                 res_valid_q, res_valid_d;
  logic [4:0]           read_data_q, read_data_d;
  logic [7:0]           masked;
  logic                 pad_bit;
  logic                 fs_we;
  logic                 fs_rdata;
  logic                 fs_clearing;
  logic [FS_AW-1:0]     fs_raddr;
  logic                 scan_go;
  scan_req_t            scan_req;
  scan_stat_t           scan_stat;

  assign busy   = fs_clearing | scan_stat.busy;
  assign accept = start & ~busy;
  assign func   = func_e'(func_i);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      allow_opp_q <= 1'b0;
      hit_thr_q   <= 9'd32;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ALLOW_OPP: allow_opp_q <= cfg_data_i[0];
        CFG_HIT_THR:   hit_thr_q   <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  // opposite directions cleared as pairs unless allow_opp is set
  always_comb begin
    masked = buttons_i;
    if (!allow_opp_q) begin
      if (masked[7:6] == 2'b11) masked[7:6] = 2'b00;
      if (masked[5:4] == 2'b11) masked[5:4] = 2'b00;
    end
  end

  // command decode for pad, latch and result register
  always_comb begin
    shift_d     = shift_q;
    bit_idx_d   = bit_idx_q;
    strobe_d    = strobe_q;
    buttons_d   = buttons_q;
    aim_col_d   = aim_col_q;
    aim_row_d   = aim_row_q;
    res_valid_d = 1'b0;
    read_data_d = read_data_q;
    pad_bit     = 1'b1;
    if (accept) begin
      case (func)
        FUNC_FRAME: begin
          buttons_d = masked;
          if (aim_y_i < 8'(SCREEN_LINES)) begin
            aim_col_d = aim_x_i;
            aim_row_d = aim_y_i;
          end else begin
            aim_col_d = 8'hFF;
            aim_row_d = 8'hFF;
          end
        end
        FUNC_PORT: begin
          if (strobe_q || strobe_bit_i) begin
            strobe_d  = strobe_bit_i;
            shift_d   = buttons_q;
            bit_idx_d = '0;
          end
        end
        FUNC_PAD: begin
          if (strobe_q) begin
            shift_d   = buttons_q;
            bit_idx_d = '0;
            pad_bit   = buttons_q[0];
          end else if (bit_idx_q < 4'd8) begin
            pad_bit   = shift_q[bit_idx_q[2:0]];
            bit_idx_d = bit_idx_q + 1'b1;
          end
          res_valid_d = 1'b1;
          read_data_d = {3'b000, pad_bit, 1'b0};
        end
        default: ;
      endcase
    end
    // sensor result from the search sequencer
    if (scan_stat.done) begin
      res_valid_d = 1'b1;
      read_data_d = {buttons_q[0], scan_stat.dark, 3'b000};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q     <= '0;
      bit_idx_q   <= '0;
      strobe_q    <= 1'b0;
      buttons_q   <= '0;
      aim_col_q   <= '0;
      aim_row_q   <= '0;
      res_valid_q <= 1'b0;
      read_data_q <= '0;
    end else begin
      shift_q     <= shift_d;
      bit_idx_q   <= bit_idx_d;
      strobe_q    <= strobe_d;
      buttons_q   <= buttons_d;
      aim_col_q   <= aim_col_d;
      aim_row_q   <= aim_row_d;
      res_valid_q <= res_valid_d;
      read_data_q <= read_data_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign read_data_o = read_data_q;

  // pixel writes go straight to the frame store
  assign fs_we = accept && (func == FUNC_PIXEL) && (pixel_row_i < 8'(SCREEN_LINES));

  lgp_frame_store u_frame_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .we_i       (fs_we),
    .waddr_i    ({pixel_row_i, pixel_col_i}),
    .wdata_i    (is_bright(pixel_color_i)),
    .raddr_i    (fs_raddr),
    .rdata_o    (fs_rdata),
    .clearing_o (fs_clearing)
  );

  // sensor search
  assign scan_go            = accept && (func == FUNC_SENSOR);
  assign scan_req.aim_col   = aim_col_q;
  assign scan_req.aim_row   = aim_row_q;
  assign scan_req.beam_line = beam_line_i;
  assign scan_req.beam_dot  = beam_dot_i;
  assign scan_req.rendering = rendering_i;

  lgp_scan u_scan (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .go_i       (scan_go),
    .req_i      (scan_req),
    .hit_thr_i  (hit_thr_q),
    .fs_rdata_i (fs_rdata),
    .fs_raddr_o (fs_raddr),
    .stat_o     (scan_stat)
  );

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives port commands into the light gun and pad port and compares every
// read result with a cycle-free predictor of the pad shifter and the sensor.
// ----------------------------------------------------------------------------

module testbench;
  import lgp_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 5;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 300;
  localparam int STALL_LIMIT   = 250000;
  localparam int HALF          = int'(WIN_HALF);
  localparam int LAG           = int'(BEAM_LAG);
  localparam int COLS          = int'(SCREEN_WIDTH);
  localparam int ROWS          = int'(SCREEN_LINES);
  localparam int LINE_MAX      = 261;
  localparam int DOT_MAX       = 340;
  localparam int THR_RESET     = 32;
  localparam int THR_MAX       = 256;
  localparam int PAD_BIT       = 1;
  localparam int DARK_BIT      = 3;
  localparam int TRIG_BIT      = 4;
  localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
  localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

  // one command on the port
  typedef struct {
    logic [2:0] func;
    logic [7:0] buttons;
    logic [7:0] aim_x;
    logic [7:0] aim_y;
    logic [7:0] pix_row;
    logic [7:0] pix_col;
    logic [5:0] pix_color;
    logic       strobe_bit;
    logic [8:0] line;
    logic [8:0] dot;
    logic       rendering;
  } port_cmd_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       start         = 1'b0;
  logic       busy;
  logic [2:0] func_i        = '0;
  logic [7:0] buttons_i     = '0;
  logic [7:0] aim_x_i       = '0;
  logic [7:0] aim_y_i       = '0;
  logic [7:0] pixel_row_i   = '0;
  logic [7:0] pixel_col_i   = '0;
  logic [5:0] pixel_color_i = '0;
  logic       strobe_bit_i  = 1'b0;
  logic [8:0] beam_line_i   = '0;
  logic [8:0] beam_dot_i    = '0;
  logic       rendering_i   = 1'b0;
  logic       cfg_we_i      = 1'b0;
  logic       cfg_idx_i     = 1'b0;
  logic [8:0] cfg_data_i    = '0;
  logic       res_valid_o;
  logic [4:0] read_data_o;

  light_gun_and_pad_port_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .func_i        (func_i),
    .buttons_i     (buttons_i),
    .aim_x_i       (aim_x_i),
    .aim_y_i       (aim_y_i),
    .pixel_row_i   (pixel_row_i),
    .pixel_col_i   (pixel_col_i),
    .pixel_color_i (pixel_color_i),
    .strobe_bit_i  (strobe_bit_i),
    .beam_line_i   (beam_line_i),
    .beam_dot_i    (beam_dot_i),
    .rendering_i   (rendering_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .res_valid_o   (res_valid_o),
    .read_data_o   (read_data_o)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // predicted device state
  logic       opp_allowed = 1'b0;
  int         hit_thr     = THR_RESET;
  logic [7:0] pad_shift   = '0;
  int         pad_idx     = 0;
  logic       pad_strobe  = 1'b0;
  logic [7:0] pad_buttons = '0;
  logic [7:0] aim_c       = '0;
  logic [7:0] aim_r       = '0;
  logic [5:0] frame_px [FS_DEPTH];

  logic [4:0] exp_read_q [$];
  int         errors      = 0;
  int         sent_count  = 0;
  int         stall_cycles = 0;
  logic       sender_gaps = 1'b1;

  function automatic logic is_lit(input logic [5:0] color);
    return (color == 6'h10) || (color >= 6'h20 && color <= 6'h2D) ||
           (color >= 6'h30 && color <= 6'h3D);
  endfunction

  function automatic logic [5:0] lit_color();
    int pick;
    pick = $urandom_range(0, 28);
    if (pick == 0) return 6'h10;
    if (pick <= 14) return 6'(8'h20 + pick - 1);
    return 6'(8'h30 + pick - 15);
  endfunction

  // bright pixel search around the aim point, as the sensor sees it
  function automatic logic [4:0] sense_light(input int line, input int dot,
                                             input logic drawing);
    int ax, ay, r0, c0, c1, r, c, hits;
    logic [4:0] d;
    d = '0;
    hits = 0;
    ax = aim_c;
    ay = aim_r;
    d[TRIG_BIT] = pad_buttons[0];
    if (ay >= ROWS) begin
      d[DARK_BIT] = 1'b1;
      return d;
    end
    if (drawing) begin
      r0 = (ay - HALF < 0) ? 0 : ay - HALF;
      c0 = (ax - HALF < 0) ? 0 : ax - HALF;
      c1 = (ax + HALF - 1 > COLS - 1) ? COLS - 1 : ax + HALF - 1;
      for (r = r0; r < ay + HALF; r++) begin
        if (r < line - LAG) continue;
        if (r > line || r >= ROWS) break;
        for (c = c0; c <= c1; c++) begin
          if (r == line && c >= dot) break;
          if (is_lit(frame_px[r * COLS + c])) hits++;
        end
      end
    end
    if (hits < hit_thr) d[DARK_BIT] = 1'b1;
    return d;
  endfunction

  // update predicted state for one accepted transaction
  task automatic apply_port_cmd(input port_cmd_t cmd);
    logic [7:0] b;
    logic [4:0] rd;
    rd = '0;
    case (cmd.func)
      FUNC_FRAME: begin
        b = cmd.buttons;
        if (!opp_allowed) begin
          if (b[7:6] == 2'b11) b[7:6] = 2'b00;
          if (b[5:4] == 2'b11) b[5:4] = 2'b00;
        end
        pad_buttons = b;
        if (cmd.aim_y < ROWS) begin
          aim_c = cmd.aim_x;
          aim_r = cmd.aim_y;
        end else begin
          aim_c = '1;
          aim_r = '1;
        end
      end
      FUNC_PIXEL: begin
        if (cmd.pix_row < ROWS)
          frame_px[int'(cmd.pix_row) * COLS + int'(cmd.pix_col)] = cmd.pix_color;
      end
      FUNC_PORT: begin
        if (pad_strobe || cmd.strobe_bit) begin
          pad_strobe = cmd.strobe_bit;
          pad_shift = pad_buttons;
          pad_idx = 0;
        end
      end
      FUNC_PAD: begin
        if (pad_strobe) begin
          pad_shift = pad_buttons;
          pad_idx = 0;
          rd[PAD_BIT] = pad_shift[0];
        end else if (pad_idx < 8) begin
          rd[PAD_BIT] = pad_shift[pad_idx];
          pad_idx++;
        end else begin
          rd[PAD_BIT] = 1'b1;
        end
        exp_read_q.push_back(rd);
      end
      FUNC_SENSOR: begin
        exp_read_q.push_back(sense_light(cmd.line, cmd.dot, cmd.rendering));
      end
      default: ;
    endcase
  endtask

  function automatic port_cmd_t rand_cmd(input logic [2:0] f);
    port_cmd_t c;
    c.func       = f;
    c.buttons    = 8'($urandom);
    c.aim_x      = 8'($urandom);
    c.aim_y      = 8'($urandom);
    c.pix_row    = 8'($urandom);
    c.pix_col    = 8'($urandom);
    c.pix_color  = 6'($urandom);
    c.strobe_bit = 1'($urandom);
    c.line       = 9'($urandom_range(0, LINE_MAX));
    c.dot        = 9'($urandom_range(0, DOT_MAX));
    c.rendering  = 1'($urandom);
    return c;
  endfunction

  task automatic pause(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // present one command and hold it until the device takes it
  task automatic send_item(input port_cmd_t cmd);
    start         <= 1'b1;
    func_i        <= cmd.func;
    buttons_i     <= cmd.buttons;
    aim_x_i       <= cmd.aim_x;
    aim_y_i       <= cmd.aim_y;
    pixel_row_i   <= cmd.pix_row;
    pixel_col_i   <= cmd.pix_col;
    pixel_color_i <= cmd.pix_color;
    strobe_bit_i  <= cmd.strobe_bit;
    beam_line_i   <= cmd.line;
    beam_dot_i    <= cmd.dot;
    rendering_i   <= cmd.rendering;
    do @(posedge clk_i); while (busy !== 1'b0);
    apply_port_cmd(cmd);
    sent_count++;
    if (sender_gaps && $urandom_range(0, 4) == 0) pause($urandom_range(1, 5));
  endtask

  // hold off until every expected result is back and the device is quiet
  task automatic wait_idle();
    start <= 1'b0;
    while (exp_read_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    while (busy !== 1'b0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [8:0] data);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_ALLOW_OPP) opp_allowed = data[0];
    else hit_thr = data;
  endtask

  task automatic set_config(input logic opp, input int thr);
    write_reg(CFG_ALLOW_OPP, {8'($urandom), opp});
    write_reg(CFG_HIT_THR, 9'(thr));
  endtask

  // frame latch, pixels around the aim point, pad activity, sensor reads
  task automatic run_scene();
    port_cmd_t c;
    int ax, ay, r_lo, r_hi, c_lo, c_hi, line, n;
    c = rand_cmd(FUNC_FRAME);
    if ($urandom_range(0, 9) != 0) c.aim_y = 8'($urandom_range(0, ROWS - 1));
    send_item(c);
    ax = c.aim_x;
    ay = (c.aim_y < ROWS) ? int'(c.aim_y) : $urandom_range(0, ROWS - 1);
    r_lo = (ay - HALF < 0) ? 0 : ay - HALF;
    r_hi = (ay + HALF - 1 > ROWS - 1) ? ROWS - 1 : ay + HALF - 1;
    c_lo = (ax - HALF < 0) ? 0 : ax - HALF;
    c_hi = (ax + HALF - 1 > COLS - 1) ? COLS - 1 : ax + HALF - 1;
    repeat ($urandom_range(4, 40)) begin
      c = rand_cmd(FUNC_PIXEL);
      c.pix_row = 8'($urandom_range(r_lo, r_hi));
      c.pix_col = 8'($urandom_range(c_lo, c_hi));
      if ($urandom_range(0, 4) < 3) c.pix_color = lit_color();
      send_item(c);
    end
    // strobe the pad and shift it out
    if ($urandom_range(0, 2) == 0) begin
      c = rand_cmd(FUNC_PORT);
      c.strobe_bit = 1'b1;
      send_item(c);
      if ($urandom_range(0, 1) == 0) send_item(rand_cmd(FUNC_PAD));
      c.strobe_bit = 1'b0;
      send_item(c);
      repeat ($urandom_range(1, 10)) send_item(rand_cmd(FUNC_PAD));
    end
    repeat ($urandom_range(1, 3)) begin
      c = rand_cmd(FUNC_SENSOR);
      n = $urandom_range(0, 40);
      line = ay + n - 2;
      if (line < 0) line = 0;
      if (line > LINE_MAX) line = LINE_MAX;
      c.line = 9'(line);
      c.rendering = ($urandom_range(0, 9) != 0);
      send_item(c);
    end
  endtask

  task automatic run_phase(input int n_items);
    int goal;
    logic [2:0] f;
    goal = sent_count + n_items;
    while (sent_count < goal) begin
      if ($urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 19) == 0) f = 3'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
        else f = 3'($urandom_range(FUNC_FRAME, FUNC_SENSOR));
        send_item(rand_cmd(f));
      end else begin
        run_scene();
      end
    end
  endtask

  // serial pad: reads before any frame, strobe reload, eight bits then ones
  task automatic test_pad_shift();
    port_cmd_t c;
    send_item(rand_cmd(FUNC_PAD));
    c = rand_cmd(FUNC_FRAME);
    c.buttons = 8'hFF;
    c.aim_x = 8'hFF;
    c.aim_y = 8'(ROWS - 1);
    send_item(c);
    c = rand_cmd(FUNC_PORT);
    c.strobe_bit = 1'b1;
    send_item(c);
    send_item(rand_cmd(FUNC_PAD));
    c.strobe_bit = 1'b0;
    send_item(c);
    repeat (9) send_item(rand_cmd(FUNC_PAD));
  endtask

  // sensor corner cases, ignored writes, unused codes, threshold extremes
  task automatic test_sensor_cases();
    port_cmd_t c;
    c = rand_cmd(FUNC_FRAME);
    c.buttons = 8'h01;
    c.aim_x = 8'h00;
    c.aim_y = 8'h00;
    send_item(c);
    c = rand_cmd(FUNC_PIXEL);
    c.pix_row = 8'h00;
    c.pix_col = 8'h00;
    c.pix_color = 6'h10;
    send_item(c);
    // row past the screen is dropped
    c.pix_row = 8'hFF;
    c.pix_color = 6'h3F;
    send_item(c);
    c = rand_cmd(FUNC_SENSOR);
    c.rendering = 1'b0;
    send_item(c);
    for (int f = FUNC_SPARE_LO; f <= FUNC_SPARE_HI; f++) send_item(rand_cmd(3'(f)));
    c = rand_cmd(FUNC_FRAME);
    c.aim_y = 8'(ROWS);
    send_item(c);
    c = rand_cmd(FUNC_SENSOR);
    c.rendering = 1'b1;
    send_item(c);
    // zero threshold sees light anywhere on screen
    write_reg(CFG_HIT_THR, '0);
    c = rand_cmd(FUNC_FRAME);
    c.aim_x = 8'h00;
    c.aim_y = 8'h00;
    send_item(c);
    c = rand_cmd(FUNC_SENSOR);
    c.line = 9'd5;
    c.dot = 9'(DOT_MAX);
    c.rendering = 1'b1;
    send_item(c);
    // threshold beyond a clipped window is never reached
    write_reg(CFG_HIT_THR, 9'(THR_MAX));
    send_item(c);
  endtask

  task automatic test_random_scenes();
    set_config(1'b1, 1);
    run_phase(260);
    set_config(1'b0, 8);
    run_phase(260);
    set_config(1'b1, 20);
    run_phase(260);
    set_config(1'b0, $urandom_range(2, 40));
    run_phase(200);
  endtask

  // whole window bright against a threshold of all 256 window pixels
  task automatic test_full_window();
    port_cmd_t c;
    int ax, ay;
    set_config(1'($urandom), THR_MAX);
    ax = $urandom_range(HALF, COLS - HALF);
    ay = $urandom_range(HALF, ROWS - HALF - 1);
    c = rand_cmd(FUNC_FRAME);
    c.aim_x = 8'(ax);
    c.aim_y = 8'(ay);
    send_item(c);
    for (int r = ay - HALF; r < ay + HALF; r++) begin
      for (int col = ax - HALF; col < ax + HALF; col++) begin
        c = rand_cmd(FUNC_PIXEL);
        c.pix_row = 8'(r);
        c.pix_col = 8'(col);
        c.pix_color = lit_color();
        send_item(c);
      end
    end
    c = rand_cmd(FUNC_SENSOR);
    c.line = 9'(ay + HALF + $urandom_range(0, LAG - 2 * HALF));
    c.dot = 9'(DOT_MAX);
    c.rendering = 1'b1;
    send_item(c);
    // beam still on the last window row
    c.line = 9'(ay + HALF - 1);
    c.dot = '0;
    send_item(c);
    c = rand_cmd(FUNC_PIXEL);
    c.pix_row = 8'(ay);
    c.pix_col = 8'(ax);
    c.pix_color = 6'h0F;
    send_item(c);
    c = rand_cmd(FUNC_SENSOR);
    c.line = 9'(ay + HALF);
    c.dot = 9'(DOT_MAX);
    c.rendering = 1'b1;
    send_item(c);
  endtask

  // back-to-back stream, no sender gaps
  task automatic test_steady_stream();
    set_config(1'b0, THR_RESET);
    sender_gaps = 1'b0;
    run_phase(150);
  endtask

  // compare each result with the oldest expectation
  always @(posedge clk_i) begin
    logic [4:0] want;
    if (rst_ni && res_valid_o === 1'b1) begin
      if (exp_read_q.size() == 0) begin
        $display("%0t: read_data expected none actual %h", $time, read_data_o);
        errors++;
      end else begin
        want = exp_read_q.pop_front();
        if (read_data_o !== want) begin
          $display("%0t: read_data expected %h actual %h", $time, want, read_data_o);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction at all
  always @(posedge clk_i) begin
    if ((start && busy === 1'b0) || res_valid_o === 1'b1) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    foreach (frame_px[i]) frame_px[i] = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_pad_shift();
    test_sensor_cases();
    test_random_scenes();
    test_full_window();
    test_steady_stream();
    start <= 1'b0;
    while (exp_read_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (exp_read_q.size() != 0)
      $display("%0t: %0d results never arrived", $time, exp_read_q.size());
    if (errors == 0 && exp_read_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
